/* rtl/fsp_pkg.sv */
// Shared widths, constants, the pipeline item type and the CORDIC arctangent table.
package fsp_pkg;

  localparam int INDEX_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_BITS   = FRAC_BITS + 2;
  localparam int GUARD_BITS = 16;
  localparam int CORD_BITS  = FRAC_BITS + GUARD_BITS + 4;
  localparam int ANG_BITS   = 32;
  localparam int ZR_BITS    = ANG_BITS + 1;
  localparam int SQ_BITS    = 2 * FRAC_BITS + 1;
  localparam int RES_BITS   = 2 * FRAC_BITS + 2;
  localparam int GAIN_BITS  = 30;

  localparam logic [31:0] GOLD_HI = 32'h61C88646;
  localparam logic [31:0] GOLD_LO = 32'h80B583EA;
  localparam logic [GAIN_BITS-1:0] GAIN_Q30 = 30'h26DD3B6A;

  typedef struct packed {
    logic                         oor;
    logic [INDEX_BITS-1:0]        n;
    logic                         neg;
    logic [INDEX_BITS:0]          rem;
    logic [FRAC_BITS:0]           q;
    logic [31:0]                  p_hi;
    logic [INDEX_BITS-1:0]        p_lo;
    logic [ANG_BITS-1:0]          ang;
    logic [1:0]                   quad;
    logic signed [ZR_BITS-1:0]    zr;
    logic signed [OUT_BITS-1:0]   yv;
    logic [RES_BITS-1:0]          yy;
    logic [SQ_BITS-1:0]           srem;
    logic [RES_BITS-1:0]          sres;
    logic [FRAC_BITS:0]           r;
    logic signed [CORD_BITS-1:0]  cx;
    logic signed [CORD_BITS-1:0]  cy;
    logic signed [OUT_BITS-1:0]   ox;
    logic signed [OUT_BITS-1:0]   oz;
  } item_t;

  // Arctangent of 2^-k in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] k);
    logic [31:0] a;
    case (k)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

/* rtl/fsp_req_if.sv */
// Request channel: point index and point count with valid/ready.
interface fsp_req_if;
  logic                             valid;
  logic                             ready;
  logic [fsp_pkg::INDEX_BITS-1:0]   point_index;
  logic [fsp_pkg::INDEX_BITS-1:0]   point_count;
  modport source(output valid, point_index, point_count, input ready);
  modport sink(input valid, point_index, point_count, output ready);
endinterface

/* rtl/fsp_res_if.sv */
// Result channel: sphere coordinates and range flag with valid/ready.
interface fsp_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [fsp_pkg::OUT_BITS-1:0] coord_x;
  logic signed [fsp_pkg::OUT_BITS-1:0] coord_y;
  logic signed [fsp_pkg::OUT_BITS-1:0] coord_z;
  logic                                out_of_range;
  modport source(output valid, coord_x, coord_y, coord_z, out_of_range, input ready);
  modport sink(input valid, coord_x, coord_y, coord_z, out_of_range, output ready);
endinterface

/* rtl/fibonacci_sphere_point.sv */
// Fibonacci sphere lattice point generator: fully pipelined divider, square root and CORDIC.
//
// Each request carries a point index and a point count and yields one result with the
// x, y and z coordinates of that point on a golden-angle Fibonacci lattice, in signed
// fixed point with 16 fraction bits. A count of zero is taken as one. When the index is
// not below the count, y is -1, x and z are 0 and out_of_range is set. The block takes
// one request per clock while its skid register is empty and delivers one result per
// clock while the consumer is ready. The stages, in order, are one input stage, 17
// restoring-divide stages at one quotient bit each, a stage that forms y and y squared,
// a stage that forms 1 - y*y, 17 square-root stages at one result bit each, a rounding
// stage, a gain multiply, one stage per CORDIC rotation and an output stage that picks
// the quadrant, rounds and clamps. The golden-angle phase is worked out alongside the
// divider. All stages advance together; a skid register on the result side holds one
// finished result while the consumer stalls, so a request can still be taken on the
// cycle the result side first stalls.
module fibonacci_sphere_point #(
  parameter int CORDIC_STEPS = 18
) (
  input  logic         clk,
  input  logic         rst,
  fsp_req_if.sink      req,
  fsp_res_if.source    res
);

  localparam int IB = fsp_pkg::INDEX_BITS;
  localparam int FB = fsp_pkg::FRAC_BITS;
  localparam int OW = fsp_pkg::OUT_BITS;
  localparam int CW = fsp_pkg::CORD_BITS;
  localparam int ZW = fsp_pkg::ZR_BITS;
  localparam int SW = fsp_pkg::SQ_BITS;
  localparam int RW = fsp_pkg::RES_BITS;
  localparam int GB = fsp_pkg::GUARD_BITS;

  // Stage map.
  localparam int DS     = FB + 1;
  localparam int S_Y    = DS + 1;
  localparam int S_RSQ  = S_Y + 1;
  localparam int S_SQ0  = S_RSQ + 1;
  localparam int SQN    = FB + 1;
  localparam int S_RND  = S_SQ0 + SQN;
  localparam int S_GAIN = S_RND + 1;
  localparam int S_COR0 = S_GAIN + 1;
  localparam int S_OUT  = S_COR0 + CORDIC_STEPS;
  localparam int NS     = S_OUT + 1;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic signed [OW-1:0] ONE_OUT = OW'(1) <<< FB;

  fsp_pkg::item_t   pipe [NS];
  fsp_pkg::item_t   nx   [NS];
  logic [NS-1:0]    vld;
  logic             en;
  fsp_pkg::item_t   hold;
  logic             hold_valid;

  // The whole pipeline moves unless the skid register is occupied.
  assign en        = !hold_valid;
  assign req.ready = en;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    if (s == 0) begin : g_in
      logic [IB-1:0]        n_eff;
      logic signed [IB+1:0] num;
      logic [IB+1:0]        mag;
      logic [IB+31:0]       prod_hi;
      logic [IB+31:0]       prod_lo;
      always_comb begin
        nx[s]   = '0;
        n_eff   = (req.point_count == '0) ? IB'(1) : req.point_count;
        num     = $signed({2'b00, n_eff}) - $signed({1'b0, req.point_index, 1'b0})
                  - $signed((IB+2)'(1));
        mag     = num[IB+1] ? (IB+2)'(-num) : (IB+2)'(num);
        prod_hi = (IB+32)'(req.point_index) * (IB+32)'(fsp_pkg::GOLD_HI);
        prod_lo = (IB+32)'(req.point_index) * (IB+32)'(fsp_pkg::GOLD_LO);
        nx[s].n    = n_eff;
        nx[s].oor  = (req.point_index >= n_eff);
        nx[s].neg  = num[IB+1];
        nx[s].rem  = mag[IB:0];
        nx[s].p_hi = prod_hi[31:0];
        nx[s].p_lo = prod_lo[IB+31:32];
      end
    end else if (s <= DS) begin : g_div
      // One quotient bit of round(|n-2i-1| * 2^FB / n) per stage.
      logic [FB:0]   n_ext;
      logic [IB+1:0] rem2;
      logic [IB+1:0] d2;
      always_comb begin
        nx[s] = pipe[s-1];
        n_ext = (FB+1)'(pipe[s-1].n);
        rem2  = {pipe[s-1].rem, n_ext[FB-(s-1)]};
        d2    = {1'b0, pipe[s-1].n, 1'b0};
        if (rem2 >= d2) begin
          nx[s].rem = (IB+1)'(rem2 - d2);
          nx[s].q   = {pipe[s-1].q[FB-1:0], 1'b1};
        end else begin
          nx[s].rem = rem2[IB:0];
          nx[s].q   = {pipe[s-1].q[FB-1:0], 1'b0};
        end
        if (s == 1) begin
          nx[s].ang = pipe[s-1].p_hi + 32'(pipe[s-1].p_lo);
        end
        if (s == 2) begin
          // Center the residual to [-1/8, 1/8) turn, bumping the quadrant when it wraps.
          nx[s].quad = pipe[s-1].ang[31:30];
          nx[s].zr   = $signed({3'b000, pipe[s-1].ang[29:0]});
          if (pipe[s-1].ang[29]) begin
            nx[s].quad = pipe[s-1].ang[31:30] + 2'd1;
            nx[s].zr   = $signed({3'b000, pipe[s-1].ang[29:0]}) - (ZW'(1) <<< 30);
          end
        end
      end
    end else if (s == S_Y) begin : g_y
      always_comb begin
        nx[s]    = pipe[s-1];
        nx[s].yv = pipe[s-1].neg ? -$signed(OW'(pipe[s-1].q)) : $signed(OW'(pipe[s-1].q));
        nx[s].yy = RW'(pipe[s-1].q) * RW'(pipe[s-1].q);
      end
    end else if (s == S_RSQ) begin : g_rsq
      logic [RW-1:0] full;
      always_comb begin
        nx[s]      = pipe[s-1];
        full       = RW'(1) << (2 * FB);
        nx[s].srem = (pipe[s-1].yy >= full) ? '0 : SW'(full - pipe[s-1].yy);
        nx[s].sres = '0;
      end
    end else if (s < S_RND) begin : g_sqrt
      // One result bit of the integer square root per stage.
      logic [RW-1:0] bitv;
      logic [RW-1:0] trial;
      always_comb begin
        nx[s] = pipe[s-1];
        bitv  = RW'(1) << (2 * (FB - (s - S_SQ0)));
        trial = pipe[s-1].sres + bitv;
        if (RW'(pipe[s-1].srem) >= trial) begin
          nx[s].srem = SW'(RW'(pipe[s-1].srem) - trial);
          nx[s].sres = (pipe[s-1].sres >> 1) + bitv;
        end else begin
          nx[s].sres = pipe[s-1].sres >> 1;
        end
      end
    end else if (s == S_RND) begin : g_rnd
      always_comb begin
        nx[s]   = pipe[s-1];
        nx[s].r = (FB+1)'(pipe[s-1].sres)
                  + (FB+1)'(RW'(pipe[s-1].srem) > pipe[s-1].sres);
      end
    end else if (s == S_GAIN) begin : g_gain
      logic [FB+30:0] prod;
      always_comb begin
        nx[s]    = pipe[s-1];
        prod     = (FB+31)'(pipe[s-1].r) * (FB+31)'(fsp_pkg::GAIN_Q30);
        nx[s].cx = $signed(CW'(prod >> (fsp_pkg::GAIN_BITS - GB)));
        nx[s].cy = '0;
      end
    end else if (s < S_OUT) begin : g_cordic
      localparam int K = s - S_COR0;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [ZW-1:0] at;
      always_comb begin
        nx[s] = pipe[s-1];
        dx    = pipe[s-1].cy >>> K;
        dy    = pipe[s-1].cx >>> K;
        at    = $signed(ZW'(fsp_pkg::atan_turn(5'(K))));
        if (!pipe[s-1].zr[ZW-1]) begin
          nx[s].cx = pipe[s-1].cx - dx;
          nx[s].cy = pipe[s-1].cy + dy;
          nx[s].zr = pipe[s-1].zr - at;
        end else begin
          nx[s].cx = pipe[s-1].cx + dx;
          nx[s].cy = pipe[s-1].cy - dy;
          nx[s].zr = pipe[s-1].zr + at;
        end
      end
    end else begin : g_out
      logic signed [CW-1:0] c;
      logic signed [CW-1:0] sn;
      logic signed [CW-1:0] vc;
      logic signed [CW-1:0] vs;
      logic signed [CW-1:0] lim;
      always_comb begin
        nx[s] = pipe[s-1];
        case (pipe[s-1].quad)
          QUAD_0:  begin c = pipe[s-1].cx;  sn = pipe[s-1].cy;  end
          QUAD_1:  begin c = -pipe[s-1].cy; sn = pipe[s-1].cx;  end
          QUAD_2:  begin c = -pipe[s-1].cx; sn = -pipe[s-1].cy; end
          QUAD_3:  begin c = pipe[s-1].cy;  sn = -pipe[s-1].cx; end
          default: begin c = pipe[s-1].cx;  sn = pipe[s-1].cy;  end
        endcase
        lim = CW'(1) <<< FB;
        vc  = (c + (CW'(1) <<< (GB - 1))) >>> GB;
        vs  = (sn + (CW'(1) <<< (GB - 1))) >>> GB;
        if (vc > lim)  vc = lim;
        if (vc < -lim) vc = -lim;
        if (vs > lim)  vs = lim;
        if (vs < -lim) vs = -lim;
        if (pipe[s-1].oor) begin
          nx[s].ox = '0;
          nx[s].oz = '0;
          nx[s].yv = -ONE_OUT;
        end else begin
          nx[s].ox = OW'(vc);
          nx[s].oz = OW'(vs);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        pipe[s] <= nx[s];
      end
    end
  end

  // Skid register: catches the last stage when the consumer stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (hold_valid) begin
      if (res.ready) hold_valid <= 1'b0;
    end else if (vld[NS-1] && !res.ready) begin
      hold_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold_valid) hold <= pipe[NS-1];
  end

  assign res.valid        = hold_valid || vld[NS-1];
  assign res.coord_x      = hold_valid ? hold.ox  : pipe[NS-1].ox;
  assign res.coord_y      = hold_valid ? hold.yv  : pipe[NS-1].yv;
  assign res.coord_z      = hold_valid ? hold.oz  : pipe[NS-1].oz;
  assign res.out_of_range = hold_valid ? hold.oor : pipe[NS-1].oor;

  // An out-of-range result always carries the fixed pole coordinates.
  a_oor_pole: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.out_of_range |->
      res.coord_x == '0 && res.coord_z == '0 && res.coord_y == -ONE_OUT)
    else $error("out-of-range result without pole coordinates");

  // Every coordinate of a delivered result lies on the closed unit interval.
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.coord_x <= ONE_OUT && res.coord_x >= -ONE_OUT &&
                  res.coord_z <= ONE_OUT && res.coord_z >= -ONE_OUT &&
                  res.coord_y <= ONE_OUT && res.coord_y >= -ONE_OUT)
    else $error("coordinate outside the unit range");

  // A stalled result is moved into the skid register rather than dropped.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    !hold_valid && vld[NS-1] && !res.ready |=> hold_valid)
    else $error("stalled result not captured by skid register");

endmodule
